// ===== rtl/vna_pkg.sv =====
// Package: shared constants and types of the vertex normal accumulator.
`timescale 1ns / 1ps
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int LIM_W            = 17;   // holds any vertex count up to 65536
  localparam int IDX_W            = 12;
  localparam int POS_W            = 24;
  localparam int VEC_W            = 24;
  localparam int CFG_W            = 13;
  localparam int EDGE_W           = 25;
  localparam int CROSS_W          = 51;
  localparam int MUL_W            = 31;
  localparam int LEN_W            = 62;
  localparam int QUO_W            = 17;
  localparam int DIV_STEPS        = 17;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FACE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PRD_A,
    ST_PRD_B,
    ST_PRD_C,
    ST_PRD_W,
    ST_XPROD,
    ST_ABS,
    ST_NORM,
    ST_SQR,
    ST_SQRT,
    ST_DIV,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SRD,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/vertex_normal_accumulator.sv =====
// Top level: vertex position store, normal sum store and face normal sequencer.
`timescale 1ns / 1ps
// Face sequence: three position reads, the cross product, normalize shifts, squares,
//   the bit-serial square root, three divides and three read-modify-writes of the sums.
// Throughput: one transaction at a time; the bit-serial square root and divider set
//   the face rate, single-port memories with registered reads set the rest.
// Reset: synchronous active-low; afterwards a clearing pass over all MAX_VERTICES
//   entries zeroes the normal sums while in_tready stays low. Positions are undefined until written.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // index_a[11:0], index_b[23:12], index_c[35:24], pos_x[59:36], pos_y[83:60],
  // pos_z[107:84], zero fill [111:108]
  input  logic [111:0]              in_tdata,
  // cmd[1:0]
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // vec_x[23:0], vec_y[47:24], vec_z[71:48], degenerate[72], saturated[73],
  // error[74], zero fill [79:75]
  output logic [79:0]               out_tdata,
  // kind[0]
  output logic                      out_tuser,
  input  logic                      cfg_we,
  input  logic [vna_pkg::CFG_W-1:0] cfg_wdata
);
  import vna_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_VERTICES);

  // memories
  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*VEC_W-1:0] sum_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_rdata_r;
  logic [3*VEC_W-1:0] sum_rdata_r;
  logic               pos_we, sum_we;
  logic [AW-1:0]      pos_addr, sum_addr;
  logic [3*VEC_W-1:0] sum_wdata;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  limit_r;
  logic [LIM_W-1:0]  lim_eff;
  logic              a_ok, b_ok, c_ok;
  cmd_t              cmd;
  logic              in_fire;

  logic [AW-1:0]     ia_r, ib_r, ic_r;
  logic [AW-1:0]     clr_cnt_r;
  logic signed [POS_W-1:0]   pa_r [3];
  logic signed [EDGE_W-1:0]  e0_r [3];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [CROSS_W-1:0] cr_r [3];
  logic [CROSS_W-1:0]        mag_r [3];
  logic [2:0]                neg_r;
  logic [4:0]                cnt_r;
  logic [1:0]                k_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;
  logic [LEN_W-1:0]          len_r;
  logic [LEN_W-1:0]          v_r, res_r, bit_r;
  logic [LEN_W-1:0]          sq_sum;
  logic [30:0]               root;
  logic [45:0]               num;
  logic [31:0]               rem_r, rem_t;
  logic [QUO_W-1:0]          lo_r, quo_r, quo_fin;
  logic                      qbit;
  logic [CROSS_W-1:0]        orv;

  logic signed [VEC_W-1:0]   vec_r [3];
  logic                      degen_r, sat_r, err_r, kind_r;
  logic                      sat_acc;
  logic signed [VEC_W:0]     acc_s [3];
  logic [VEC_W-1:0]          acc_v [3];

  logic                      out_valid_r;
  logic [79:0]               out_data_r;
  logic                      out_kind_r;
  logic                      out_load;

  // -------- input decode --------
  assign cmd      = cmd_t'(in_tuser);
  assign in_fire  = in_tvalid && in_tready;
  assign lim_eff  = (LIM_W'(limit_r) < MAX_LIM) ? LIM_W'(limit_r) : MAX_LIM;
  assign a_ok     = LIM_W'(in_tdata[11:0])  < lim_eff;
  assign b_ok     = LIM_W'(in_tdata[23:12]) < lim_eff;
  assign c_ok     = LIM_W'(in_tdata[35:24]) < lim_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // -------- next state --------
  assign out_load = !out_valid_r || out_tready;
  assign orv      = mag_r[0] | mag_r[1] | mag_r[2];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_WRITE: state_nxt = ST_IDLE;
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_READ:  state_nxt = a_ok ? ST_SRD : ST_DONE;
            CMD_FACE:  state_nxt = (a_ok && b_ok && c_ok) ? ST_PRD_A : ST_DONE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRD_A:  state_nxt = ST_PRD_B;
      ST_PRD_B:  state_nxt = ST_PRD_C;
      ST_PRD_C:  state_nxt = ST_PRD_W;
      ST_PRD_W:  state_nxt = ST_XPROD;
      ST_XPROD:  if (cnt_r == 5'd6) state_nxt = ST_ABS;
      ST_ABS:    state_nxt = ST_NORM;
      ST_NORM: begin
        if (orv == '0) begin
          state_nxt = ST_DONE;
        end else if (orv[CROSS_W-1:30] == '0 && orv[29]) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR:    if (cnt_r == 5'd3) state_nxt = ST_SQRT;
      ST_SQRT:   if (bit_r == '0) state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 5'(DIV_STEPS) && k_r == 2'd2) state_nxt = ST_ACC_RD;
      ST_ACC_RD: state_nxt = ST_ACC_WR;
      ST_ACC_WR: state_nxt = (k_r == 2'd2) ? ST_DONE : ST_ACC_RD;
      ST_SRD:    state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // -------- outputs of the sequencer: handshake and memory ports --------
  always_comb begin
    in_tready = 1'b0;
    pos_we    = 1'b0;
    pos_addr  = ia_r;
    sum_we    = 1'b0;
    sum_addr  = ia_r;
    sum_wdata = '0;
    case (state_r)
      ST_CLR: begin
        sum_we   = 1'b1;
        sum_addr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        pos_we    = in_fire && (cmd == CMD_WRITE) && a_ok;
        pos_addr  = AW'(in_tdata[11:0]);
      end
      ST_PRD_A:  pos_addr = ia_r;
      ST_PRD_B:  pos_addr = ib_r;
      ST_PRD_C:  pos_addr = ic_r;
      ST_ACC_RD: sum_addr = (k_r == 2'd0) ? ia_r : ((k_r == 2'd1) ? ib_r : ic_r);
      ST_ACC_WR: begin
        sum_we    = 1'b1;
        sum_addr  = (k_r == 2'd0) ? ia_r : ((k_r == 2'd1) ? ib_r : ic_r);
        sum_wdata = {acc_v[2], acc_v[1], acc_v[0]};
      end
      ST_SRD:    sum_addr = ia_r;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_addr] <= in_tdata[107:36];
    end else begin
      pos_rdata_r <= pos_mem[pos_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end else begin
      sum_rdata_r <= sum_mem[sum_addr];
    end
  end

  // -------- shared multiplier: cross product terms, then squares --------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_XPROD) begin
      case (cnt_r)
        5'd0: begin mul_a = MUL_W'(e0_r[1]); mul_b = MUL_W'(e1_r[2]); end
        5'd1: begin mul_a = MUL_W'(e0_r[2]); mul_b = MUL_W'(e1_r[1]); end
        5'd2: begin mul_a = MUL_W'(e0_r[2]); mul_b = MUL_W'(e1_r[0]); end
        5'd3: begin mul_a = MUL_W'(e0_r[0]); mul_b = MUL_W'(e1_r[2]); end
        5'd4: begin mul_a = MUL_W'(e0_r[0]); mul_b = MUL_W'(e1_r[1]); end
        5'd5: begin mul_a = MUL_W'(e0_r[1]); mul_b = MUL_W'(e1_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (cnt_r)
        5'd0:    begin mul_a = {1'b0, mag_r[0][29:0]}; mul_b = {1'b0, mag_r[0][29:0]}; end
        5'd1:    begin mul_a = {1'b0, mag_r[1][29:0]}; mul_b = {1'b0, mag_r[1][29:0]}; end
        5'd2:    begin mul_a = {1'b0, mag_r[2][29:0]}; mul_b = {1'b0, mag_r[2][29:0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // square root step, divider step, saturating adds
  assign sq_sum  = res_r + bit_r;
  assign root    = res_r[30:0];
  assign num     = {1'b0, mag_r[k_r][29:0], 15'd0} + 46'(root[30:1]);
  assign rem_t   = {rem_r[30:0], lo_r[QUO_W-1]};
  assign qbit    = rem_t >= {1'b0, root};
  assign quo_fin = {quo_r[QUO_W-2:0], qbit};

  always_comb begin
    sat_acc = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc_s[i] = (VEC_W+1)'($signed(sum_rdata_r[i*VEC_W +: VEC_W])) + (VEC_W+1)'(vec_r[i]);
      if (acc_s[i][VEC_W] != acc_s[i][VEC_W-1]) begin
        sat_acc  = 1'b1;
        acc_v[i] = acc_s[i][VEC_W] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
      end else begin
        acc_v[i] = acc_s[i][VEC_W-1:0];
      end
    end
  end

  // -------- datapath --------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLR) begin
      clr_cnt_r <= (clr_cnt_r == LAST_ADDR) ? '0 : clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        ia_r    <= AW'(in_tdata[11:0]);
        ib_r    <= AW'(in_tdata[23:12]);
        ic_r    <= AW'(in_tdata[35:24]);
        kind_r  <= (cmd == CMD_FACE);
        err_r   <= (cmd == CMD_FACE) ? !(a_ok && b_ok && c_ok) : !a_ok;
        degen_r <= 1'b0;
        sat_r   <= 1'b0;
        cnt_r   <= '0;
        k_r     <= '0;
        for (int i = 0; i < 3; i++) vec_r[i] <= '0;
      end
      ST_PRD_B: begin
        for (int i = 0; i < 3; i++) pa_r[i] <= pos_rdata_r[i*POS_W +: POS_W];
      end
      ST_PRD_C: begin
        for (int i = 0; i < 3; i++)
          e0_r[i] <= EDGE_W'($signed(pos_rdata_r[i*POS_W +: POS_W])) - EDGE_W'(pa_r[i]);
      end
      ST_PRD_W: begin
        for (int i = 0; i < 3; i++)
          e1_r[i] <= EDGE_W'($signed(pos_rdata_r[i*POS_W +: POS_W])) - EDGE_W'(pa_r[i]);
      end
      ST_XPROD: begin
        // consume the product registered in the previous step
        if (cnt_r != 5'd0) begin
          if (cnt_r[0]) begin
            cr_r[2'((cnt_r - 5'd1) >> 1)] <= CROSS_W'(prod_r);
          end else begin
            cr_r[2'((cnt_r - 5'd1) >> 1)] <= cr_r[2'((cnt_r - 5'd1) >> 1)] - CROSS_W'(prod_r);
          end
        end
        cnt_r <= (cnt_r == 5'd6) ? '0 : cnt_r + 1'b1;
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][CROSS_W-1];
          mag_r[i] <= cr_r[i][CROSS_W-1] ? CROSS_W'(-cr_r[i]) : CROSS_W'(cr_r[i]);
        end
      end
      ST_NORM: begin
        // one bit of scaling per cycle until the top magnitude sits in [2^29, 2^30); all zero marks degenerate
        if (orv == '0) begin
          degen_r <= 1'b1;
        end else if (orv[CROSS_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!orv[29]) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
        len_r <= '0;
        cnt_r <= '0;
      end
      ST_SQR: begin
        if (cnt_r != 5'd0) len_r <= len_r + LEN_W'(prod_r);
        cnt_r <= (cnt_r == 5'd3) ? '0 : cnt_r + 1'b1;
        if (cnt_r == 5'd3) begin
          v_r   <= len_r + LEN_W'(prod_r);
          res_r <= '0;
          bit_r <= LEN_W'(1) << 60;
        end
      end
      ST_SQRT: begin
        if (bit_r != '0) begin
          if (v_r >= sq_sum) begin
            v_r   <= v_r - sq_sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        cnt_r <= '0;
        k_r   <= '0;
      end
      ST_DIV: begin
        if (cnt_r == 5'd0) begin
          rem_r <= 32'(num[45:QUO_W]);
          lo_r  <= num[QUO_W-1:0];
          quo_r <= '0;
          cnt_r <= 5'd1;
        end else begin
          rem_r <= qbit ? rem_t - {1'b0, root} : rem_t;
          lo_r  <= lo_r << 1;
          quo_r <= quo_fin;
          if (cnt_r == 5'(DIV_STEPS)) begin
            vec_r[k_r] <= neg_r[k_r] ? -VEC_W'(quo_fin) : VEC_W'(quo_fin);
            cnt_r      <= '0;
            k_r        <= (k_r == 2'd2) ? 2'd0 : k_r + 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
      end
      ST_ACC_WR: begin
        sat_r <= sat_r | sat_acc;
        k_r   <= k_r + 1'b1;
      end
      ST_SRD: begin
        // data of the read issued in this cycle arrives in the done cycle
      end
      default: begin
      end
    endcase
  end

  // read command result comes straight from the sum memory; hold the selection
  // for as long as the done state waits on the output register
  logic rd_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == ST_SRD) || (rd_pend_r && state_r == ST_DONE && !out_load);
    end
  end

  // -------- output register --------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_load) begin
      out_kind_r <= kind_r;
      if (rd_pend_r) begin
        out_data_r <= {5'd0, err_r, 1'b0, 1'b0, sum_rdata_r};
      end else begin
        out_data_r <= {5'd0, err_r, sat_r, degen_r, vec_r[2], vec_r[1], vec_r[0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("input taken outside idle");
  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[72] && !out_tdata[73])
    else $error("read result carries face flags");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[74] |-> out_tdata[71:0] == '0 && !out_tdata[72])
    else $error("error result carries data");
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |-> !in_tready && sum_we)
    else $error("clearing pass not exclusive");
`endif

endmodule
